[rtl/qau_pkg.sv]
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; used by qau_lane, qau_div and the core top level.
package qau_pkg;

   // Product slots per lane and quaternion components per word.
   localparam int NUM_TERMS = 4;

   // Component positions inside operand and result arrays.
   localparam int COMP_X = 0;
   localparam int COMP_Y = 1;
   localparam int COMP_Z = 2;
   localparam int COMP_W = 3;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_ROT   = 3'd3,
      OP_INV   = 3'd4,
      OP_DOT   = 3'd5,
      OP_SCALE = 3'd6
   } op_type;

endpackage

[rtl/qau_lane.sv]
// One multiply-accumulate lane: four signed products, summed exactly,
// floored by SHIFT bits and clamped. Two register stages. Uses qau_pkg.
module qau_lane #(
   parameter int DATA_WIDTH = 16,
   parameter int SHIFT      = 12
) (
   input  logic                          clock,
   input  logic                          go,
   input  logic signed [DATA_WIDTH-1:0]  op_a [qau_pkg::NUM_TERMS],
   input  logic signed [DATA_WIDTH-1:0]  op_b [qau_pkg::NUM_TERMS],
   input  logic [qau_pkg::NUM_TERMS-1:0] neg,
   output logic signed [2*DATA_WIDTH+1:0] sum_floor,
   output logic signed [DATA_WIDTH-1:0]   sum_sat,
   output logic                           sum_clip
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int SW = 2 * DATA_WIDTH + 2;

   logic signed [PW-1:0]         prod_ff [qau_pkg::NUM_TERMS];
   logic [qau_pkg::NUM_TERMS-1:0] neg_ff;
   logic signed [SW-1:0]         total;
   logic signed [SW-1:0]         floor_in;
   logic [SW-DATA_WIDTH:0]       hi_bits;
   logic                         clip_in;
   logic signed [DATA_WIDTH-1:0] sat_in;
   logic signed [SW-1:0]         floor_ff;
   logic signed [DATA_WIDTH-1:0] sat_ff;
   logic                         clip_ff;

   always_ff @(posedge clock) begin
      if (go) begin
         for (int i = 0; i < qau_pkg::NUM_TERMS; i++) begin
            prod_ff[i] <= op_a[i] * op_b[i];
         end
         neg_ff <= neg;
      end
   end

   // exact sum, then arithmetic shift = floor
   always_comb begin
      total = '0;
      for (int i = 0; i < qau_pkg::NUM_TERMS; i++) begin
         if (neg_ff[i]) begin
            total = total - SW'(prod_ff[i]);
         end else begin
            total = total + SW'(prod_ff[i]);
         end
      end
      floor_in = total >>> SHIFT;
      hi_bits  = floor_in[SW-1:DATA_WIDTH-1];
      clip_in  = !((&hi_bits) || (~|hi_bits));
      if (clip_in) begin
         sat_in = {floor_in[SW-1], {(DATA_WIDTH-1){~floor_in[SW-1]}}};
      end else begin
         sat_in = floor_in[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         floor_ff <= floor_in;
         sat_ff   <= sat_in;
         clip_ff  <= clip_in;
      end
   end

   assign sum_floor = floor_ff;
   assign sum_sat   = sat_ff;
   assign sum_clip  = clip_ff;

endmodule

[rtl/qau_div.sv]
// Pipelined restoring divider, one quotient bit per stage, four lanes
// sharing one divisor. Uses qau_pkg for the lane count.
module qau_div #(
   parameter int QUO_WIDTH = 28,
   parameter int DEN_WIDTH = 33
) (
   input  logic                          clock,
   input  logic                          go,
   input  logic [QUO_WIDTH-1:0]          num [qau_pkg::NUM_TERMS],
   input  logic [DEN_WIDTH-1:0]          den,
   output logic [QUO_WIDTH-1:0]          quo [qau_pkg::NUM_TERMS],
   output logic [qau_pkg::NUM_TERMS-1:0] rem_nz
);

   logic [QUO_WIDTH-1:0] acc_ff [QUO_WIDTH][qau_pkg::NUM_TERMS];
   logic [DEN_WIDTH-1:0] rem_ff [QUO_WIDTH][qau_pkg::NUM_TERMS];
   logic [DEN_WIDTH-1:0] den_ff [QUO_WIDTH];

   for (genvar s = 0; s < QUO_WIDTH; s++) begin : g_step
      logic [QUO_WIDTH-1:0] acc_src [qau_pkg::NUM_TERMS];
      logic [DEN_WIDTH-1:0] rem_src [qau_pkg::NUM_TERMS];
      logic [DEN_WIDTH-1:0] den_src;
      logic [QUO_WIDTH-1:0] acc_in  [qau_pkg::NUM_TERMS];
      logic [DEN_WIDTH-1:0] rem_in  [qau_pkg::NUM_TERMS];
      logic [DEN_WIDTH:0]   trial   [qau_pkg::NUM_TERMS];
      logic [DEN_WIDTH:0]   diff    [qau_pkg::NUM_TERMS];

      always_comb begin
         for (int c = 0; c < qau_pkg::NUM_TERMS; c++) begin
            if (s == 0) begin
               acc_src[c] = num[c];
               rem_src[c] = '0;
            end else begin
               acc_src[c] = acc_ff[(s == 0) ? 0 : s-1][c];
               rem_src[c] = rem_ff[(s == 0) ? 0 : s-1][c];
            end
         end
         den_src = (s == 0) ? den : den_ff[(s == 0) ? 0 : s-1];
         for (int c = 0; c < qau_pkg::NUM_TERMS; c++) begin
            trial[c] = {rem_src[c], acc_src[c][QUO_WIDTH-1]};
            diff[c]  = trial[c] - {1'b0, den_src};
            if (trial[c] >= {1'b0, den_src}) begin
               rem_in[c] = diff[c][DEN_WIDTH-1:0];
               acc_in[c] = {acc_src[c][QUO_WIDTH-2:0], 1'b1};
            end else begin
               rem_in[c] = trial[c][DEN_WIDTH-1:0];
               acc_in[c] = {acc_src[c][QUO_WIDTH-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (go) begin
            acc_ff[s] <= acc_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < qau_pkg::NUM_TERMS; c++) begin
         quo[c]    = acc_ff[QUO_WIDTH-1][c];
         rem_nz[c] = |rem_ff[QUO_WIDTH-1][c];
      end
   end

endmodule

[rtl/quaternion_arithmetic_unit_core.sv]
// Quaternion arithmetic unit, signed fixed point (Q4.12 by default).
// Input channel req_*: one word per operation, opcode plus A, B and scalar.
// Result channel rsp_*: exactly one word per accepted request, in order.
// A word is accepted on an edge where valid and ready are both high.
// Structure: four multiply lanes form the first pass (products, dot, norm,
// cross product u), six lanes form the second pass (q x u and 2w*u for
// rotation), a merge stage picks the result, and a one-bit-per-stage
// divider pipeline (DATA_WIDTH+FRAC_BITS stages) serves the inverse.
// Every opcode flows through the same pipe, so order is kept.
// Throughput: one word per cycle while the output buffer has room.
// A two-word output buffer sits at the end; the whole pipe advances while
// that buffer has room, so the input keeps flowing while one result waits.
// When the buffer is full the pipe freezes and req_ready drops.
// Reset (synchronous, active high) empties the pipe and the buffer.
// Inverse of a zero-norm A gives zero and rsp_zero_norm; opcode 7 gives
// zero with both flags clear.
module quaternion_arithmetic_unit_core #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_type,
   input  logic signed [DATA_WIDTH-1:0] req_a_x,
   input  logic signed [DATA_WIDTH-1:0] req_a_y,
   input  logic signed [DATA_WIDTH-1:0] req_a_z,
   input  logic signed [DATA_WIDTH-1:0] req_a_w,
   input  logic signed [DATA_WIDTH-1:0] req_b_x,
   input  logic signed [DATA_WIDTH-1:0] req_b_y,
   input  logic signed [DATA_WIDTH-1:0] req_b_z,
   input  logic signed [DATA_WIDTH-1:0] req_b_w,
   input  logic signed [DATA_WIDTH-1:0] req_scale_factor,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_r_x,
   output logic signed [DATA_WIDTH-1:0] rsp_r_y,
   output logic signed [DATA_WIDTH-1:0] rsp_r_z,
   output logic signed [DATA_WIDTH-1:0] rsp_r_w,
   output logic                         rsp_zero_norm,
   output logic                         rsp_saturated
);

   localparam int W   = DATA_WIDTH;
   localparam int NT  = qau_pkg::NUM_TERMS;
   localparam int SW  = 2 * W + 2;               // lane floor width
   localparam int QB  = W + FRAC_BITS;           // divider quotient bits
   localparam int DW  = 2 * W + 1;               // norm width
   localparam int XW  = (2 * W + 4 > QB + 2) ? 2 * W + 4 : QB + 2;
   localparam int L   = QB + 4;                  // pipe stages before buffer

   typedef struct packed {
      qau_pkg::op_type   op;
      logic [NT-1:0][W-1:0] a;
      logic [NT-1:0][W-1:0] b;
      logic [NT-1:0][W-1:0] ra;     // first-pass clamped results
      logic              clip_a;
      logic [DW-1:0]     norm;
   } pipe_type;

   typedef struct packed {
      logic [NT-1:0][W-1:0] r;
      logic              sat;
      logic              zn;
      logic              inv;
      logic [NT-1:0]     neg;
   } pass_type;

   typedef struct packed {
      logic [NT-1:0][W-1:0] r;
      logic              zn;
      logic              sat;
   } out_type;

   typedef struct packed {
      logic         clip;
      logic [W-1:0] val;
   } clip_type;

   function automatic clip_type clamp_fn(input logic signed [XW-1:0] v);
      clip_type c;
      logic [XW-W:0] hi;
      hi     = v[XW-1:W-1];
      c.clip = !((&hi) || (~|hi));
      c.val  = c.clip ? {v[XW-1], {(W-1){~v[XW-1]}}} : v[W-1:0];
      return c;
   endfunction

   // ---------------- flow control ----------------
   logic          go;
   logic [L-1:0]  v_ff;
   logic [1:0]    cnt_ff, cnt_in;
   out_type       slot_ff [2];
   out_type       slot_in [2];
   out_type       fin;
   logic          push, pop;

   assign go        = (cnt_ff != 2'd2);
   assign req_ready = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (go) begin
         v_ff <= {v_ff[L-2:0], req_valid};
      end
   end

   // ---------------- first pass: four lanes ----------------
   logic signed [W-1:0] in_a [NT];
   logic signed [W-1:0] in_b [NT];
   qau_pkg::op_type     op_in;

   assign in_a[qau_pkg::COMP_X] = req_a_x;
   assign in_a[qau_pkg::COMP_Y] = req_a_y;
   assign in_a[qau_pkg::COMP_Z] = req_a_z;
   assign in_a[qau_pkg::COMP_W] = req_a_w;
   assign in_b[qau_pkg::COMP_X] = req_b_x;
   assign in_b[qau_pkg::COMP_Y] = req_b_y;
   assign in_b[qau_pkg::COMP_Z] = req_b_z;
   assign in_b[qau_pkg::COMP_W] = req_b_w;
   assign op_in = qau_pkg::op_type'(req_type);

   logic signed [W-1:0] la_a [NT][NT];
   logic signed [W-1:0] la_b [NT][NT];
   logic [NT-1:0]       la_neg [NT];

   always_comb begin
      for (int l = 0; l < NT; l++) begin
         la_neg[l] = '0;
         for (int t = 0; t < NT; t++) begin
            la_a[l][t] = '0;
            la_b[l][t] = '0;
         end
      end
      case (op_in)
         qau_pkg::OP_MUL: begin
            // Hamilton product, one component per lane
            la_a[0][0] = req_a_w; la_b[0][0] = req_b_x;
            la_a[0][1] = req_a_x; la_b[0][1] = req_b_w;
            la_a[0][2] = req_a_y; la_b[0][2] = req_b_z;
            la_a[0][3] = req_a_z; la_b[0][3] = req_b_y; la_neg[0][3] = 1'b1;
            la_a[1][0] = req_a_w; la_b[1][0] = req_b_y;
            la_a[1][1] = req_a_y; la_b[1][1] = req_b_w;
            la_a[1][2] = req_a_z; la_b[1][2] = req_b_x;
            la_a[1][3] = req_a_x; la_b[1][3] = req_b_z; la_neg[1][3] = 1'b1;
            la_a[2][0] = req_a_w; la_b[2][0] = req_b_z;
            la_a[2][1] = req_a_z; la_b[2][1] = req_b_w;
            la_a[2][2] = req_a_x; la_b[2][2] = req_b_y;
            la_a[2][3] = req_a_y; la_b[2][3] = req_b_x; la_neg[2][3] = 1'b1;
            la_a[3][0] = req_a_w; la_b[3][0] = req_b_w;
            la_a[3][1] = req_a_x; la_b[3][1] = req_b_x;
            la_a[3][2] = req_a_y; la_b[3][2] = req_b_y;
            la_a[3][3] = req_a_z; la_b[3][3] = req_b_z;
            la_neg[3] = 4'b1110;
         end
         qau_pkg::OP_ROT: begin
            // u = q x v
            la_a[0][0] = req_a_y; la_b[0][0] = req_b_z;
            la_a[0][1] = req_a_z; la_b[0][1] = req_b_y; la_neg[0][1] = 1'b1;
            la_a[1][0] = req_a_z; la_b[1][0] = req_b_x;
            la_a[1][1] = req_a_x; la_b[1][1] = req_b_z; la_neg[1][1] = 1'b1;
            la_a[2][0] = req_a_x; la_b[2][0] = req_b_y;
            la_a[2][1] = req_a_y; la_b[2][1] = req_b_x; la_neg[2][1] = 1'b1;
         end
         qau_pkg::OP_INV: begin
            // squared norm on the w lane
            for (int t = 0; t < NT; t++) begin
               la_a[3][t] = in_a[t];
               la_b[3][t] = in_a[t];
            end
         end
         qau_pkg::OP_DOT: begin
            for (int t = 0; t < NT; t++) begin
               la_a[3][t] = in_a[t];
               la_b[3][t] = in_b[t];
            end
         end
         qau_pkg::OP_SCALE: begin
            for (int l = 0; l < NT; l++) begin
               la_a[l][0] = in_a[l];
               la_b[l][0] = req_scale_factor;
            end
         end
         default: begin
         end
      endcase
   end

   logic signed [SW-1:0] a_floor [NT];
   logic signed [W-1:0]  a_sat   [NT];
   logic [NT-1:0]        a_clip;

   for (genvar l = 0; l < NT; l++) begin : g_lane_a
      qau_lane #(.DATA_WIDTH(W), .SHIFT(FRAC_BITS)) u_lane (
         .clock     (clock),
         .go        (go),
         .op_a      (la_a[l]),
         .op_b      (la_b[l]),
         .neg       (la_neg[l]),
         .sum_floor (a_floor[l]),
         .sum_sat   (a_sat[l]),
         .sum_clip  (a_clip[l])
      );
   end

   pipe_type p1_ff, p2_ff, p3_ff, p4_ff;
   pipe_type p3_in;

   always_comb begin
      p3_in = p2_ff;
      for (int l = 0; l < NT; l++) begin
         p3_in.ra[l] = a_sat[l];
      end
      // the norm lane may clip, but only the quotient counts for inverse
      p3_in.clip_a = (p2_ff.op == qau_pkg::OP_INV) ? 1'b0 : (|a_clip);
      p3_in.norm   = a_floor[qau_pkg::COMP_W][DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (go) begin
         p1_ff.op     <= op_in;
         p1_ff.ra     <= '0;
         p1_ff.clip_a <= 1'b0;
         p1_ff.norm   <= '0;
         for (int i = 0; i < NT; i++) begin
            p1_ff.a[i] <= in_a[i];
            p1_ff.b[i] <= in_b[i];
         end
         p2_ff <= p1_ff;
         p3_ff <= p3_in;
         p4_ff <= p3_ff;
      end
   end

   // ---------------- second pass: rotation lanes ----------------
   logic signed [W-1:0] lb_a [3][NT];
   logic signed [W-1:0] lb_b [3][NT];
   logic [NT-1:0]       lb_neg [3];
   logic signed [W-1:0] lw_a [3][NT];
   logic signed [W-1:0] lw_b [3][NT];
   logic signed [W-1:0] qa [NT];
   logic signed [W-1:0] u  [3];

   always_comb begin
      for (int i = 0; i < NT; i++) begin
         qa[i] = p3_in.a[i];
      end
      for (int i = 0; i < 3; i++) begin
         u[i] = a_sat[i];
      end
      for (int l = 0; l < 3; l++) begin
         lb_neg[l] = 4'b0010;
         for (int t = 0; t < NT; t++) begin
            lb_a[l][t] = '0;
            lb_b[l][t] = '0;
            lw_a[l][t] = '0;
            lw_b[l][t] = '0;
         end
         lw_a[l][0] = qa[qau_pkg::COMP_W];
         lw_b[l][0] = u[l];
      end
      // uu = q x u
      lb_a[0][0] = qa[qau_pkg::COMP_Y]; lb_b[0][0] = u[2];
      lb_a[0][1] = qa[qau_pkg::COMP_Z]; lb_b[0][1] = u[1];
      lb_a[1][0] = qa[qau_pkg::COMP_Z]; lb_b[1][0] = u[0];
      lb_a[1][1] = qa[qau_pkg::COMP_X]; lb_b[1][1] = u[2];
      lb_a[2][0] = qa[qau_pkg::COMP_X]; lb_b[2][0] = u[1];
      lb_a[2][1] = qa[qau_pkg::COMP_Y]; lb_b[2][1] = u[0];
   end

   logic signed [SW-1:0] uu_floor [3];
   logic signed [W-1:0]  uu_sat   [3];
   logic [2:0]           uu_clip;
   logic signed [SW-1:0] wu_floor [3];
   logic signed [W-1:0]  wu_sat   [3];
   logic [2:0]           wu_clip;

   for (genvar l = 0; l < 3; l++) begin : g_lane_b
      qau_lane #(.DATA_WIDTH(W), .SHIFT(FRAC_BITS)) u_cross (
         .clock     (clock),
         .go        (go),
         .op_a      (lb_a[l]),
         .op_b      (lb_b[l]),
         .neg       (lb_neg[l]),
         .sum_floor (uu_floor[l]),
         .sum_sat   (uu_sat[l]),
         .sum_clip  (uu_clip[l])
      );
      // 2*w*u: one less bit of shift gives the factor two
      qau_lane #(.DATA_WIDTH(W), .SHIFT(FRAC_BITS - 1)) u_wterm (
         .clock     (clock),
         .go        (go),
         .op_a      (lw_a[l]),
         .op_b      (lw_b[l]),
         .neg       (4'b0000),
         .sum_floor (wu_floor[l]),
         .sum_sat   (wu_sat[l]),
         .sum_clip  (wu_clip[l])
      );
   end

   // ---------------- merge stage ----------------
   pass_type            mg;
   logic [QB-1:0]       dv_num [NT];
   logic [W-1:0]        mag    [NT];
   logic signed [XW-1:0] wide  [NT];
   clip_type            cl     [NT];
   logic                any_clip;
   logic                spare_clip;

   always_comb begin
      mg       = '0;
      any_clip = 1'b0;
      for (int i = 0; i < NT; i++) begin
         wide[i] = '0;
         cl[i]   = '0;
         mag[i]  = p4_ff.a[i][W-1] ? (~p4_ff.a[i] + 1'b1) : p4_ff.a[i];
         dv_num[i] = {mag[i], {FRAC_BITS{1'b0}}};
      end
      // the 2*w*u lane result is used unclamped
      spare_clip = (|wu_clip) & (wu_sat[0] == wu_sat[1]) & 1'b0;
      case (p4_ff.op)
         qau_pkg::OP_ADD, qau_pkg::OP_SUB: begin
            for (int i = 0; i < NT; i++) begin
               if (p4_ff.op == qau_pkg::OP_ADD) begin
                  wide[i] = XW'($signed(p4_ff.a[i])) + XW'($signed(p4_ff.b[i]));
               end else begin
                  wide[i] = XW'($signed(p4_ff.a[i])) - XW'($signed(p4_ff.b[i]));
               end
               cl[i]    = clamp_fn(wide[i]);
               mg.r[i]  = cl[i].val;
               any_clip = any_clip | cl[i].clip;
            end
            mg.sat = any_clip;
         end
         qau_pkg::OP_MUL, qau_pkg::OP_SCALE: begin
            mg.r   = p4_ff.ra;
            mg.sat = p4_ff.clip_a;
         end
         qau_pkg::OP_DOT: begin
            mg.r[qau_pkg::COMP_W] = p4_ff.ra[qau_pkg::COMP_W];
            mg.sat = p4_ff.clip_a;
         end
         qau_pkg::OP_ROT: begin
            // v + floor(2*w*u) + 2*uu
            for (int i = 0; i < 3; i++) begin
               wide[i] = XW'($signed(p4_ff.b[i])) + XW'(wu_floor[i])
                       + (XW'(uu_sat[i]) <<< 1);
               cl[i]    = clamp_fn(wide[i]);
               mg.r[i]  = cl[i].val;
               any_clip = any_clip | cl[i].clip;
            end
            mg.sat = any_clip | p4_ff.clip_a | (|uu_clip) | spare_clip;
         end
         qau_pkg::OP_INV: begin
            mg.zn  = (p4_ff.norm == '0);
            mg.inv = !mg.zn;
            for (int i = 0; i < 3; i++) begin
               // -a is negative when a is positive
               mg.neg[i] = !p4_ff.a[i][W-1] && (p4_ff.a[i] != '0);
            end
            mg.neg[qau_pkg::COMP_W] = p4_ff.a[qau_pkg::COMP_W][W-1];
         end
         default: begin
         end
      endcase
   end

   // ---------------- inverse divider and pass-through ----------------
   logic [QB-1:0] quo [NT];
   logic [NT-1:0] rem_nz;
   pass_type      pass_ff [QB];

   qau_div #(.QUO_WIDTH(QB), .DEN_WIDTH(DW)) u_div (
      .clock  (clock),
      .go     (go),
      .num    (dv_num),
      .den    (p4_ff.norm),
      .quo    (quo),
      .rem_nz (rem_nz)
   );

   always_ff @(posedge clock) begin
      if (go) begin
         pass_ff[0] <= mg;
         for (int s = 1; s < QB; s++) begin
            pass_ff[s] <= pass_ff[s-1];
         end
      end
   end

   // floor correction for negative quotients, then clamp
   logic signed [XW-1:0] qv [NT];
   clip_type             qc [NT];

   always_comb begin
      fin.r   = pass_ff[QB-1].r;
      fin.zn  = pass_ff[QB-1].zn;
      fin.sat = pass_ff[QB-1].sat;
      for (int i = 0; i < NT; i++) begin
         if (pass_ff[QB-1].neg[i]) begin
            qv[i] = -XW'(quo[i]) - XW'(rem_nz[i]);
         end else begin
            qv[i] = XW'(quo[i]);
         end
         qc[i] = clamp_fn(qv[i]);
         if (pass_ff[QB-1].inv) begin
            fin.r[i] = qc[i].val;
            fin.sat  = fin.sat | qc[i].clip;
         end
      end
   end

   // ---------------- two-word output buffer ----------------
   assign push = go && v_ff[L-1];
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in     = cnt_ff;
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd0) begin
            slot_in[0] = fin;
         end else begin
            slot_in[1] = fin;
         end
      end else if (pop && !push) begin
         cnt_in     = cnt_ff - 2'd1;
         slot_in[0] = slot_ff[1];
      end else if (pop && push) begin
         slot_in[0] = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_valid     = (cnt_ff != 2'd0);
   assign rsp_r_x       = slot_ff[0].r[qau_pkg::COMP_X];
   assign rsp_r_y       = slot_ff[0].r[qau_pkg::COMP_Y];
   assign rsp_r_z       = slot_ff[0].r[qau_pkg::COMP_Z];
   assign rsp_r_w       = slot_ff[0].r[qau_pkg::COMP_W];
   assign rsp_zero_norm = slot_ff[0].zn;
   assign rsp_saturated = slot_ff[0].sat;

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req_ready)
      else $error("input accepted with full output buffer");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[L-1] && !go) |=> v_ff[L-1])
      else $error("last stage word lost during stall");

   a_zero_norm_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm) |-> (!rsp_saturated && rsp_r_x == '0
         && rsp_r_y == '0 && rsp_r_z == '0 && rsp_r_w == '0))
      else $error("zero-norm result not cleared");
`endif

endmodule
